[rtl/dcs_pkg.sv]
`timescale 1ns / 1ps

package dcs_pkg;

    // number of sectors in one scan, bounds the error count
    localparam int SECTOR_COUNT = 1024;

    localparam int          ERR_W   = 11;
    localparam int          ERR_CAP = (SECTOR_COUNT < 2047) ? SECTOR_COUNT : 2047;
    localparam logic [ERR_W-1:0] ERR_CAP_V = ERR_W'(ERR_CAP);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  BYTE_MASK = 8'hFF;

    typedef enum logic [1:0] {
        ACT_BOTH_GOOD = 2'd0,
        ACT_FIX_COPY1 = 2'd1,
        ACT_FIX_COPY2 = 2'd2,
        ACT_BOTH_BAD  = 2'd3
    } t_action;

    // control carried from the crc stage to the merge stage
    typedef struct packed {
        logic last;
        logic clear;
    } t_merge_ctl;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data & BYTE_MASK};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // four bytes, low byte first
    function automatic logic [31:0] crc32_word(input logic [31:0] crc,
                                               input logic [31:0] word);
        logic [31:0] c;
        c = crc;
        for (int b = 0; b < 4; b++) begin
            c = crc32_byte(c, word[8*b +: 8]);
        end
        return c;
    endfunction

endpackage

[rtl/dual_copy_sector_crc_scrubber.sv]
`timescale 1ns / 1ps

// dual-copy sector crc scrubber: each accepted word carries one 32-bit word of
// both copies of a sector; two crc-32 lanes (reflected 0xEDB88320, init all
// ones, final inversion, low byte first) run side by side, one word per cycle
// each, so a new word is taken every clock while the output is free. a word
// with last_word set yields one result, registered in crc and merge stages:
// the repair action, the checksum records after the decision, the saturating
// error count and the sticky write-back flags. words without last_word give
// no result. rate is one word per cycle, set by the combinational four-byte
// crc update in each lane; input stall rises only when a finished result is
// held by output stall and the next last word reaches the merge stage.
// new_scan clears the count and flags ahead of its own word.
module dual_copy_sector_crc_scrubber (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_new_scan,
    input  logic [31:0] i_copy1_word,
    input  logic [31:0] i_copy2_word,
    input  logic [31:0] i_stored_sum1,
    input  logic [31:0] i_stored_sum2,
    input  logic        i_last_word,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_repair_action,
    output logic [31:0] o_new_sum1,
    output logic [31:0] o_new_sum2,
    output logic [dcs_pkg::ERR_W-1:0] o_error_total,
    output logic        o_rewrite_table1,
    output logic        o_rewrite_table2
);
    import dcs_pkg::*;

    // crc stage: one word held between the lanes and the merge stage
    logic        r_s1_valid;
    t_merge_ctl  r_s1_ctl;
    logic [31:0] r_s1_sum1;
    logic [31:0] r_s1_sum2;

    logic        in_take;
    logic        s1_take;
    logic [31:0] crc1;
    logic [31:0] crc2;

    // the merge stage only blocks on a last word with the output slot full and stalled
    assign s1_take = r_s1_valid && (!r_s1_ctl.last || !o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_take;
    assign in_take = i_valid && !o_stall;

    dcs_crc_lane u_lane1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_take),
        .i_last  (i_last_word),
        .i_word  (i_copy1_word),
        .o_crc   (crc1)
    );

    dcs_crc_lane u_lane2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_take),
        .i_last  (i_last_word),
        .i_word  (i_copy2_word),
        .o_crc   (crc2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stored sums and control travel with the word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_ctl.last  <= i_last_word;
            r_s1_ctl.clear <= i_new_scan;
            r_s1_sum1      <= i_stored_sum1;
            r_s1_sum2      <= i_stored_sum2;
        end
    end

    // compare, decide, count and hold the result
    dcs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (s1_take),
        .i_ctl       (r_s1_ctl),
        .i_crc1      (crc1),
        .i_crc2      (crc2),
        .i_sum1      (r_s1_sum1),
        .i_sum2      (r_s1_sum2),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_action    (o_repair_action),
        .o_sum1      (o_new_sum1),
        .o_sum2      (o_new_sum2),
        .o_errors    (o_error_total),
        .o_dirty1    (o_rewrite_table1),
        .o_dirty2    (o_rewrite_table2)
    );

`ifndef ASSERT_OFF
    // error count never passes its cap
    a_err_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_error_total <= ERR_CAP_V))
        else $error("error count above cap");

    // both bad: both records take copy 1's crc
    a_both_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_repair_action == ACT_BOTH_BAD)) |->
        (o_new_sum1 == o_new_sum2 && o_rewrite_table1 && o_rewrite_table2))
        else $error("both-bad result inconsistent");

    // a repaired copy 1 always has its write-back flag set
    a_fix_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_repair_action == ACT_FIX_COPY1)) |-> o_rewrite_table1)
        else $error("copy 1 repair without write-back flag");

    // input stalls only behind a held last word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_s1_ctl.last && o_valid && i_stall))
        else $error("input stall without a blocked result");
`endif

endmodule

[rtl/dcs_crc_lane.sv]
`timescale 1ns / 1ps

module dcs_crc_lane (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_last,
    input  logic [31:0] i_word,
    output logic [31:0] o_crc
);
    import dcs_pkg::*;

    logic [31:0] r_crc;
    logic [31:0] n_crc;
    logic [31:0] r_fin;

    assign n_crc = crc32_word(r_crc, i_word);
    assign o_crc = r_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_ONES;
        end else if (i_load) begin
            r_crc <= i_last ? CRC_ONES : n_crc;
        end
    end

    // finished crc, meaningful only after a last word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fin <= ~n_crc;
        end
    end

endmodule

[rtl/dcs_merge.sv]
`timescale 1ns / 1ps

module dcs_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  dcs_pkg::t_merge_ctl  i_ctl,
    input  logic [31:0]          i_crc1,
    input  logic [31:0]          i_crc2,
    input  logic [31:0]          i_sum1,
    input  logic [31:0]          i_sum2,
    input  logic                 i_out_stall,
    output logic                 o_valid,
    output logic [1:0]           o_action,
    output logic [31:0]          o_sum1,
    output logic [31:0]          o_sum2,
    output logic [dcs_pkg::ERR_W-1:0] o_errors,
    output logic                 o_dirty1,
    output logic                 o_dirty2
);
    import dcs_pkg::*;

    logic             r_valid;
    logic [ERR_W-1:0] r_cnt;
    logic             r_dirty1;
    logic             r_dirty2;
    t_action          r_action;
    logic [31:0]      r_sum1;
    logic [31:0]      r_sum2;
    // count and flags as they stood at the last word, held with the result
    logic [ERR_W-1:0] r_out_cnt;
    logic             r_out_dirty1;
    logic             r_out_dirty2;

    logic             n_valid;
    logic [ERR_W-1:0] n_cnt;
    logic             n_dirty1;
    logic             n_dirty2;
    t_action          n_action;
    logic [31:0]      n_sum1;
    logic [31:0]      n_sum2;
    logic             ok1;
    logic             ok2;
    logic [ERR_W-1:0] base_cnt;
    logic [ERR_W-1:0] inc_cnt;

    assign ok1      = (i_crc1 == i_sum1);
    assign ok2      = (i_crc2 == i_sum2);
    assign base_cnt = i_ctl.clear ? '0 : r_cnt;
    assign inc_cnt  = (base_cnt < ERR_CAP_V) ? base_cnt + ERR_W'(1) : base_cnt;

    always_comb begin
        n_cnt    = base_cnt;
        n_dirty1 = i_ctl.clear ? 1'b0 : r_dirty1;
        n_dirty2 = i_ctl.clear ? 1'b0 : r_dirty2;
        n_sum1   = i_sum1;
        n_sum2   = i_sum2;
        n_action = ACT_BOTH_GOOD;
        if (ok1 && ok2) begin
            n_action = ACT_BOTH_GOOD;
        end else if (!ok1 && ok2) begin
            n_action = ACT_FIX_COPY1;
            n_sum1   = i_crc2;
            n_dirty1 = 1'b1;
            n_cnt    = inc_cnt;
        end else if (ok1 && !ok2) begin
            n_action = ACT_FIX_COPY2;
            n_sum2   = i_crc1;
            n_dirty2 = 1'b1;
            n_cnt    = inc_cnt;
        end else begin
            n_action = ACT_BOTH_BAD;
            n_sum1   = i_crc1;
            n_sum2   = i_crc1;
            n_dirty1 = 1'b1;
            n_dirty2 = 1'b1;
        end
        if (!i_ctl.last) begin
            n_cnt = base_cnt;
            n_dirty1 = i_ctl.clear ? 1'b0 : r_dirty1;
            n_dirty2 = i_ctl.clear ? 1'b0 : r_dirty2;
        end
    end

    always_comb begin
        n_valid = r_valid && i_out_stall;
        if (i_take && i_ctl.last) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_cnt    <= '0;
            r_dirty1 <= 1'b0;
            r_dirty2 <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_take) begin
                r_cnt    <= n_cnt;
                r_dirty1 <= n_dirty1;
                r_dirty2 <= n_dirty2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_ctl.last) begin
            r_action     <= n_action;
            r_sum1       <= n_sum1;
            r_sum2       <= n_sum2;
            r_out_cnt    <= n_cnt;
            r_out_dirty1 <= n_dirty1;
            r_out_dirty2 <= n_dirty2;
        end
    end

    assign o_valid  = r_valid;
    assign o_action = r_action;
    assign o_sum1   = r_sum1;
    assign o_sum2   = r_sum2;
    assign o_errors = r_out_cnt;
    assign o_dirty1 = r_out_dirty1;
    assign o_dirty2 = r_out_dirty2;

endmodule
